### design/arc_pkg.sv
// shared types, constants and color table for the annulus row compositor
package arc_pkg;

   localparam int RING_SLOTS   = 3;
   localparam int BANDS        = 9;
   localparam int PANEL_WIDTH  = 480;
   localparam int PANEL_HEIGHT = 480;

   localparam int EDGES      = BANDS + 1;
   localparam int SLOT_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
   localparam int EDGE_W     = $clog2(EDGES);
   localparam int BAND_W     = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int ROOT_STEPS = 11;
   localparam int ITER_W     = $clog2(ROOT_STEPS);

   localparam longint unsigned CUBE_DIV   = 64'd255 * 64'd255 * 64'd255;
   localparam longint unsigned SQUARE_DIV = 64'd255 * 64'd255;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_BAND   = 2'd1,
      KIND_ROW    = 2'd2,
      KIND_PIXEL  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [1:0]         ring_sel;
      logic [3:0]         band_sel;
      logic signed [11:0] center_x;
      logic signed [11:0] center_y;
      logic [3:0]         band_count;
      logic [10:0]        edge_radius;
      logic [7:0]         band_level;
      logic [8:0]         row_y;
      logic [8:0]         col_x;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_color;
      logic [7:0]  intensity;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_DY,
      ST_ROW_SQ,
      ST_ROW_DIFF,
      ST_ROW_ROOT,
      ST_PIX_SCAN,
      ST_PIX_DONE
   } state_type;

   typedef struct packed {
      logic              load_req;
      logic              dy_calc;
      logic              sq_calc;
      logic              row_check;
      logic              root_step;
      logic              root_last;
      logic              scan;
      logic              rsp_load;
      logic [SLOT_W-1:0] slot;
      logic [EDGE_W-1:0] edge_idx;
   } cmd_type;

   typedef struct packed {
      logic       diff_hit;
      logic [3:0] cur_nb;
      logic       rsp_busy;
   } stat_type;

   typedef logic [15:0] rom_type [0:255];

   // shift and subtract quotient, good for quotients below 256
   function automatic logic [7:0] quot8(input longint unsigned num,
                                        input longint unsigned den);
      logic [7:0]      q;
      longint unsigned rest;
      rest = num;
      q    = '0;
      for (int b = 7; b >= 0; b--) begin
         if (rest >= (den << b)) begin
            rest = rest - (den << b);
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic rom_type build_rom();
      rom_type          t;
      logic [7:0]       r;
      logic [7:0]       g;
      longint unsigned  v;
      for (int i = 0; i < 256; i++) begin
         v = longint'(i);
         r = quot8(64'd30 * v * v * v, CUBE_DIV);
         g = quot8(64'd140 * v * v, SQUARE_DIV);
         t[i] = {r[7:3], g[7:2], v[7:3]};
      end
      return t;
   endfunction

   localparam rom_type COLOR_ROM = build_rom();

endpackage

### design/arc_ctl.sv
// sequencer for row setup and pixel scan of the annulus row compositor
module arc_ctl import arc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  kind_type req_kind,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [EDGE_W-1:0] edge_ff, edge_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              accept;
   logic              slot_last;
   logic              edge_last_row;
   logic              edge_last_pix;
   logic              iter_last;

   assign req_ready     = (state_ff == ST_IDLE);
   assign accept        = req_valid & req_ready;
   assign slot_last     = (32'(slot_ff) == RING_SLOTS - 1);
   assign edge_last_row = (32'(edge_ff) == BANDS);
   assign edge_last_pix = (32'(edge_ff) == 32'(stat.cur_nb));
   assign iter_last     = (32'(iter_ff) == ROOT_STEPS - 1);

   // next state and counters
   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      edge_in  = edge_ff;
      iter_in  = iter_ff;
      unique case (state_ff)
         ST_IDLE: begin
            slot_in = '0;
            edge_in = '0;
            if (accept) begin
               if (req_kind == KIND_ROW)   state_in = ST_ROW_DY;
               if (req_kind == KIND_PIXEL) state_in = ST_PIX_SCAN;
            end
         end
         ST_ROW_DY: begin
            state_in = ST_ROW_SQ;
         end
         ST_ROW_SQ: begin
            state_in = ST_ROW_DIFF;
         end
         ST_ROW_DIFF, ST_ROW_ROOT: begin
            iter_in = '0;
            if (state_ff == ST_ROW_DIFF && stat.diff_hit) begin
               state_in = ST_ROW_ROOT;
            end else if (state_ff == ST_ROW_ROOT && !iter_last) begin
               iter_in = iter_ff + 1'b1;
            end else if (edge_last_row) begin
               edge_in = '0;
               if (slot_last) begin
                  state_in = ST_IDLE;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  state_in = ST_ROW_DY;
               end
            end else begin
               edge_in  = edge_ff + 1'b1;
               state_in = ST_ROW_SQ;
            end
         end
         ST_PIX_SCAN: begin
            if (edge_last_pix) begin
               edge_in = '0;
               if (slot_last) state_in = ST_PIX_DONE;
               else           slot_in  = slot_ff + 1'b1;
            end else begin
               edge_in = edge_ff + 1'b1;
            end
         end
         ST_PIX_DONE: begin
            if (!stat.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd           = '0;
      cmd.load_req  = accept;
      cmd.slot      = slot_ff;
      cmd.edge_idx  = edge_ff;
      unique case (state_ff)
         ST_IDLE:     ;
         ST_ROW_DY:   cmd.dy_calc   = 1'b1;
         ST_ROW_SQ:   cmd.sq_calc   = 1'b1;
         ST_ROW_DIFF: cmd.row_check = 1'b1;
         ST_ROW_ROOT: begin
            cmd.root_step = 1'b1;
            cmd.root_last = iter_last;
         end
         ST_PIX_SCAN: cmd.scan      = 1'b1;
         ST_PIX_DONE: cmd.rsp_load  = !stat.rsp_busy;
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
         edge_ff  <= '0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         edge_ff  <= edge_in;
         iter_ff  <= iter_in;
      end
   end

endmodule

### design/arc_dp.sv
// ring storage, half chord root unit and band accumulator
module arc_dp import arc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   logic signed [11:0] cx_ff [RING_SLOTS];
   logic signed [11:0] cy_ff [RING_SLOTS];
   logic [3:0]         nb_ff [RING_SLOTS];
   logic [10:0]        edge_mem [RING_SLOTS][EDGES];
   logic [7:0]         level_mem [RING_SLOTS][BANDS];
   logic [10:0]        ext_val_ff [RING_SLOTS][EDGES];
   logic               ext_miss_ff [RING_SLOTS][EDGES];

   logic [8:0]         row_ff;
   logic [8:0]         col_ff;
   logic [22:0]        dy2_ff;
   logic [21:0]        e2_ff;
   logic [21:0]        rem_ff, rem_in;
   logic [21:0]        res_ff, res_in;
   logic [21:0]        bit_ff;
   logic [10:0]        prev_val_ff;
   logic               prev_miss_ff;
   logic [7:0]         sum_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [SLOT_W-1:0]  wslot;
   logic [EDGE_W-1:0]  wedge;
   logic               slot_ok;
   logic signed [12:0] dy;
   logic signed [25:0] dy_sq;
   logic signed [23:0] diff;
   logic               row_on;
   logic [22:0]        trial;
   logic [10:0]        cur_val;
   logic               cur_miss;
   logic [BAND_W-1:0]  band_idx;
   logic signed [12:0] dx;
   logic [11:0]        adx;
   logic               hit;
   logic [8:0]         sum_add;

   assign wslot   = SLOT_W'(req_data.ring_sel);
   assign wedge   = EDGE_W'(req_data.band_sel);
   assign slot_ok = (32'(req_data.ring_sel) < RING_SLOTS);

   // row setup arithmetic
   assign dy     = $signed({4'b0, row_ff}) - 13'(cy_ff[cmd.slot]);
   assign dy_sq  = dy * dy;
   assign diff   = $signed({2'b0, e2_ff}) - $signed({1'b0, dy2_ff});
   assign row_on = (32'(row_ff) < PANEL_HEIGHT);
   assign trial  = {1'b0, res_ff} + {1'b0, bit_ff};

   always_comb begin
      rem_in = rem_ff;
      res_in = res_ff >> 1;
      if ({1'b0, rem_ff} >= trial) begin
         rem_in = rem_ff - trial[21:0];
         res_in = (res_ff >> 1) + bit_ff;
      end
   end

   // pixel scan: band edge_idx-1 spans previous extent to current one
   assign cur_val  = ext_val_ff[cmd.slot][cmd.edge_idx];
   assign cur_miss = ext_miss_ff[cmd.slot][cmd.edge_idx];
   assign band_idx = (cmd.edge_idx == '0) ? '0 : BAND_W'(cmd.edge_idx - 1'b1);
   assign dx       = $signed({4'b0, col_ff}) - 13'(cx_ff[cmd.slot]);
   assign adx      = dx[12] ? 12'(-dx) : dx[11:0];
   assign hit      = (cmd.edge_idx != '0) && (32'(col_ff) < PANEL_WIDTH) && !cur_miss
                     && ({1'b0, adx} <= {2'b0, cur_val})
                     && (prev_miss_ff || ({1'b0, adx} >= {2'b0, prev_val_ff}));
   assign sum_add  = {1'b0, sum_ff} + {1'b0, level_mem[cmd.slot][band_idx]};

   assign stat.diff_hit = row_on && !diff[23] && (diff != '0);
   assign stat.cur_nb   = nb_ff[cmd.slot];
   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;

   // ring parameters and extents
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < RING_SLOTS; s++) begin
            cx_ff[s] <= '0;
            cy_ff[s] <= '0;
            nb_ff[s] <= '0;
            for (int k = 0; k < EDGES; k++) ext_miss_ff[s][k] <= 1'b1;
         end
      end else begin
         if (cmd.load_req && req_data.kind == KIND_HEADER && slot_ok) begin
            cx_ff[wslot] <= req_data.center_x;
            cy_ff[wslot] <= req_data.center_y;
            nb_ff[wslot] <= (32'(req_data.band_count) > BANDS) ? 4'(BANDS)
                                                                : req_data.band_count;
         end
         if (cmd.row_check && !stat.diff_hit) begin
            ext_miss_ff[cmd.slot][cmd.edge_idx] <= 1'b1;
         end
         if (cmd.root_last) begin
            ext_miss_ff[cmd.slot][cmd.edge_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req && req_data.kind == KIND_BAND && slot_ok
          && 32'(req_data.band_sel) <= BANDS) begin
         edge_mem[wslot][wedge] <= req_data.edge_radius;
         if (32'(req_data.band_sel) < BANDS) begin
            level_mem[wslot][BAND_W'(req_data.band_sel)] <= req_data.band_level;
         end
      end
      if (cmd.root_last) begin
         ext_val_ff[cmd.slot][cmd.edge_idx] <= res_in[10:0];
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         row_ff <= req_data.row_y;
         col_ff <= req_data.col_x;
         sum_ff <= '0;
      end
      if (cmd.dy_calc) dy2_ff <= dy_sq[22:0];
      if (cmd.sq_calc) e2_ff  <= 22'(edge_mem[cmd.slot][cmd.edge_idx])
                                 * 22'(edge_mem[cmd.slot][cmd.edge_idx]);
      if (cmd.row_check) begin
         rem_ff <= diff[21:0];
         res_ff <= '0;
         bit_ff <= 22'(1) << (2 * (ROOT_STEPS - 1));
      end
      if (cmd.root_step) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.scan) begin
         prev_val_ff  <= cur_val;
         prev_miss_ff <= cur_miss;
         if (hit) sum_ff <= sum_add[8] ? 8'hFF : sum_add[7:0];
      end
      if (cmd.rsp_load) begin
         rsp_ff.pixel_color <= COLOR_ROM[sum_ff];
         rsp_ff.intensity   <= sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/annulus_row_compositor_unit.sv
// top level of the annulus row compositor
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    req_type
//   rsp_      out         rsp_valid/rsp_ready    rsp_type
//
// header and band requests are written straight into the ring store on accept
// start row: per slot a dy step, then per edge a square step and a check step, plus 11 root steps
//   when the chord exists; no new request is taken until every slot and edge is through
// pixel query: scans edge 0 through the last band in use of each slot, then loads the
//   result register once the previous response has been taken
// synchronous active high reset clears ring parameters and marks all extents missed
// a pending response does not block new requests; a query waits only to load it
module annulus_row_compositor_unit import arc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // controller to datapath command bundle and status back
   cmd_type  cmd;
   stat_type stat;

   // sequencer: row setup loop over slots and edges, pixel scan loop
   arc_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, root unit, accumulator and result register
   arc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### tb/tb.sv
// self-checking testbench for the annulus row compositor unit
`timescale 1ns / 100ps

module tb;
   import arc_pkg::*;

   typedef struct {
      req_type item;
      bit      drain;
   } pending_type;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE      = 500;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   annulus_row_compositor_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // shadow of the block's ring store and current row extents
   logic signed [11:0] shadow_cx [RING_SLOTS];
   logic signed [11:0] shadow_cy [RING_SLOTS];
   logic [3:0]         shadow_nb [RING_SLOTS];
   logic [10:0]        shadow_edge [RING_SLOTS][EDGES];
   logic [7:0]         shadow_level [RING_SLOTS][BANDS];
   int                 shadow_chord [RING_SLOTS][EDGES];
   logic [15:0]        gradient [256];

   pending_type pending_q[$];
   rsp_type     expected_pixels[$];
   int          errors;
   int          pixels_checked;
   int          rows_started;
   int          cycles;
   int          send_pause;
   int          send_calm;
   int          recv_pause;
   int          recv_calm;
   bit          drain_next;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mismatch reporting
   task automatic report(input string what, input int got, input int want);
      $display("tb: mismatch %s got %0d want %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // integer floor square root, one result bit per step
   function automatic int floor_root(input int v);
      int r;
      int t;
      r = 0;
      for (int b = 11; b >= 0; b--) begin
         t = r | (1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // column inside a span clipped to the panel
   function automatic bit covers(input int x, input int lo, input int hi);
      if (lo < 0) lo = 0;
      if (hi > PANEL_WIDTH - 1) hi = PANEL_WIDTH - 1;
      return lo <= hi && x >= lo && x <= hi;
   endfunction

   // update the shadow store for one accepted request, queue a pixel if any
   task automatic apply_request(input req_type q);
      int      y;
      int      dy;
      int      e2;
      int      x;
      int      c;
      int      outer;
      int      inner;
      int      sum;
      bit      hit;
      rsp_type r;
      case (q.kind)
         KIND_HEADER: begin
            if (q.ring_sel < RING_SLOTS) begin
               shadow_cx[q.ring_sel] = q.center_x;
               shadow_cy[q.ring_sel] = q.center_y;
               shadow_nb[q.ring_sel] = (q.band_count > BANDS) ? 4'(BANDS) : q.band_count;
            end
         end
         KIND_BAND: begin
            if (q.ring_sel < RING_SLOTS && q.band_sel <= BANDS) begin
               shadow_edge[q.ring_sel][q.band_sel] = q.edge_radius;
               if (q.band_sel < BANDS) shadow_level[q.ring_sel][q.band_sel] = q.band_level;
            end
         end
         KIND_ROW: begin
            rows_started++;
            y = int'(q.row_y);
            for (int s = 0; s < RING_SLOTS; s++) begin
               dy = y - int'(shadow_cy[s]);
               for (int k = 0; k < EDGES; k++) begin
                  e2 = int'(shadow_edge[s][k]) * int'(shadow_edge[s][k]) - dy * dy;
                  shadow_chord[s][k] = (y >= PANEL_HEIGHT || e2 <= 0) ? -1 : floor_root(e2);
               end
            end
         end
         default: begin
            x = int'(q.col_x);
            sum = 0;
            if (x < PANEL_WIDTH) begin
               for (int s = 0; s < RING_SLOTS; s++) begin
                  c = int'(shadow_cx[s]);
                  for (int k = 0; k < int'(shadow_nb[s]); k++) begin
                     outer = shadow_chord[s][k + 1];
                     inner = shadow_chord[s][k];
                     if (outer >= 0) begin
                        if (inner < 0) hit = covers(x, c - outer, c + outer);
                        else hit = covers(x, c - outer, c - inner) ||
                                   covers(x, c + inner, c + outer);
                        if (hit) begin
                           sum += shadow_level[s][k];
                           if (sum > 255) sum = 255;
                        end
                     end
                  end
               end
            end
            r.intensity   = 8'(sum);
            r.pixel_color = gradient[sum];
            expected_pixels.push_back(r);
         end
      endcase
   endtask

   function automatic int pause_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // request driver
   always @(posedge clock) begin
      bit          hold;
      pending_type nxt;
      if (reset) begin
         req_valid  <= 1'b0;
         send_pause = 0;
         send_calm  = 0;
      end else begin
         hold = 1'b0;
         if (req_valid && req_ready) apply_request(req_data);
         else hold = req_valid;
         if (!hold) begin
            if (send_pause > 0) begin
               send_pause--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain && expected_pixels.size() > 0)) begin
               nxt        = pending_q.pop_front();
               req_data  <= nxt.item;
               req_valid <= 1'b1;
               // calm stretches give back-to-back requests
               if (send_calm > 0) send_calm--;
               else if ($urandom_range(0, 59) == 0) send_calm = $urandom_range(20, 80);
               send_pause = (send_calm > 0) ? 0 : pause_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and backpressure
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_pause = 0;
         recv_calm  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report("unexpected pixel intensity", rsp_data.intensity, -1);
            end else begin
               want = expected_pixels.pop_front();
               pixels_checked++;
               if (rsp_data.intensity !== want.intensity)
                  report("intensity", rsp_data.intensity, want.intensity);
               if (rsp_data.pixel_color !== want.pixel_color)
                  report("pixel_color", rsp_data.pixel_color, want.pixel_color);
            end
         end
         if (recv_pause > 0) begin
            recv_pause--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (recv_calm > 0) recv_calm--;
            else if ($urandom_range(0, 59) == 0) recv_calm = $urandom_range(20, 80);
            recv_pause = (recv_calm > 0) ? 0 : pause_len();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycles);
         $display("tb: errors");
         $finish;
      end
   end

   // request builders, unused fields keep random bits
   function automatic req_type noise();
      logic [95:0] w;
      w = {$urandom, $urandom, $urandom};
      return w[$bits(req_type)-1:0];
   endfunction

   task automatic push(input req_type q);
      pending_type p;
      p.item     = q;
      p.drain    = drain_next;
      drain_next = 1'b0;
      pending_q.push_back(p);
   endtask

   task automatic add_header(input int slot, input int cx, input int cy, input int n);
      req_type q;
      q            = noise();
      q.kind       = KIND_HEADER;
      q.ring_sel   = 2'(slot);
      q.center_x   = 12'(cx);
      q.center_y   = 12'(cy);
      q.band_count = 4'(n);
      push(q);
   endtask

   task automatic add_band(input int slot, input int b, input int radius, input int lvl);
      req_type q;
      q             = noise();
      q.kind        = KIND_BAND;
      q.ring_sel    = 2'(slot);
      q.band_sel    = 4'(b);
      q.edge_radius = 11'(radius);
      q.band_level  = 8'(lvl);
      push(q);
   endtask

   task automatic add_row(input int y);
      req_type q;
      q       = noise();
      q.kind  = KIND_ROW;
      q.row_y = 9'(y);
      push(q);
   endtask

   task automatic add_pixel(input int x);
      req_type q;
      q       = noise();
      q.kind  = KIND_PIXEL;
      q.col_x = 9'(x);
      push(q);
   endtask

   // one ring, not always well-formed, with a few rows of queries across it
   task automatic add_ring_scene();
      int slot;
      int cx;
      int cy;
      int radius;
      int rows;
      int span;
      slot = $urandom_range(0, RING_SLOTS - 1);
      if ($urandom_range(0, 9) == 0) begin
         cx = $signed(12'($urandom));
         cy = $signed(12'($urandom));
      end else begin
         cx = $urandom_range(0, 880) - 200;
         cy = $urandom_range(0, 880) - 200;
      end
      add_header(slot, cx, cy, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                           : $urandom_range(1, BANDS));
      if ($urandom_range(0, 3) != 0) begin
         radius = $urandom_range(0, 60);
         for (int b = 0; b < EDGES; b++) begin
            add_band(slot, b, radius, $urandom_range(0, 255));
            // mostly ascending, now and then reversed or a huge step
            if ($urandom_range(0, 19) == 0) radius = $urandom_range(0, 2047);
            else radius = radius + $urandom_range(0, 60);
            if (radius > 2047) radius = 2047;
         end
         span = radius;
      end else begin
         span = 300;
      end
      rows = $urandom_range(1, 3);
      for (int r = 0; r < rows; r++) begin
         if ($urandom_range(0, 3) == 0) add_row($urandom_range(0, 511));
         else add_row((cy + $urandom_range(0, 2 * span) - span) & 9'h1ff);
         repeat ($urandom_range(5, 30)) begin
            if ($urandom_range(0, 3) == 0) add_pixel($urandom_range(0, 511));
            else add_pixel((cx + $urandom_range(0, 2 * span) - span) & 9'h1ff);
         end
      end
   endtask

   // stimulus and end of run
   initial begin
      longint unsigned rv;
      longint unsigned gv;
      errors         = 0;
      pixels_checked = 0;
      rows_started   = 0;
      cycles         = 0;
      drain_next     = 1'b0;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      reset          = 1'b1;
      for (int i = 0; i < 256; i++) begin
         rv = 64'd30 * i * i * i / (64'd255 * 255 * 255);
         gv = 64'd140 * i * i / (64'd255 * 255);
         gradient[i] = {rv[7:3], gv[7:2], 5'(i >> 3)};
      end
      for (int s = 0; s < RING_SLOTS; s++) begin
         shadow_cx[s] = '0;
         shadow_cy[s] = '0;
         shadow_nb[s] = '0;
         for (int k = 0; k < EDGES; k++) shadow_chord[s][k] = -1;
      end

      // fill every edge and level first so no row start reads an unwritten entry
      for (int s = 0; s < RING_SLOTS; s++)
         for (int b = 0; b < EDGES; b++) add_band(s, b, 10 + 20 * b + 5 * s, 40 + 20 * b);

      // directed corners
      add_pixel(240);                       // extents still all missed
      add_header(0, 240, 240, 9);
      add_header(1, -2048, 2047, 15);       // count above the band limit
      add_header(2, 2047, -2048, 0);        // disabled slot
      add_header(3, 100, 100, 5);           // slot out of range, dropped
      add_band(3, 0, 2047, 255);            // dropped
      add_band(0, 12, 7, 7);                // edge index out of range, dropped
      add_row(240);
      add_pixel(0);
      add_pixel(240);
      add_pixel(479);
      add_pixel(480);                       // off the panel
      add_pixel(511);
      add_band(0, 3, 5, 255);               // reversed edge, stale until next row
      add_band(0, 9, 2047, 0);              // last edge only
      add_header(1, 240, 240, 9);           // overlap to saturate
      add_pixel(240);
      add_row(479);
      add_pixel(250);
      add_row(480);                         // row off the panel
      add_pixel(240);
      add_row(0);
      add_pixel(0);
      add_pixel(479);

      while (pending_q.size() < 1750) begin
         if (pending_q.size() > 900 && pending_q.size() < 920) drain_next = 1'b1;
         if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 4)) push(noise());
         end else begin
            add_ring_scene();
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait (pending_q.size() == 0 && !req_valid && expected_pixels.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (expected_pixels.size() != 0)
         report("pixels never returned", expected_pixels.size(), 0);

      $display("tb: %0d pixel queries checked across %0d row starts", pixels_checked,
               rows_started);
      $display("tb: %0d cycles, %0d mismatches", cycles, errors);
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

### filelist.f
design/arc_pkg.sv
design/arc_ctl.sv
design/arc_dp.sv
design/annulus_row_compositor_unit.sv
tb/tb.sv
